### rtl/rgi_pkg.sv
package rgi_pkg;

  localparam int IMAGE_WIDTH = 176;
  localparam int COL_W       = $clog2(IMAGE_WIDTH + 1);
  localparam int ADDR_W      = $clog2(IMAGE_WIDTH);

  localparam int PIX_W       = 8;
  localparam int ROW_W       = 18;
  localparam int AREA_W      = 24;

  // 3R + 6G + B fits in 12 bits; divide by 10 as (x * 6554) >> 16
  localparam int GRAY_SUM_W  = 12;
  localparam int RECIP_W     = 13;
  localparam int RECIP_10    = 6554;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = GRAY_SUM_W + RECIP_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [PIX_W-1:0] gray;
    logic [COL_W-1:0] col;
    logic             in_line;
    logic             first_row;
    logic             row_start;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

### rtl/rgi_front.sv
module rgi_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rgi_pkg::PIX_W-1:0] red,
  input  logic [rgi_pkg::PIX_W-1:0] green,
  input  logic [rgi_pkg::PIX_W-1:0] blue,
  input  logic                      row_start,
  input  logic                      frame_first_row,
  input  logic                      take,
  output rgi_pkg::item_t            item
);
  import rgi_pkg::*;

  logic [COL_W-1:0]      col_cnt;
  logic [COL_W-1:0]      col_cur;
  logic [COL_W-1:0]      col_cnt_next;
  logic                  in_line;
  logic [GRAY_SUM_W-1:0] red_w;
  logic [GRAY_SUM_W-1:0] green_w;
  logic [GRAY_SUM_W-1:0] weighted;
  logic [PROD_W-1:0]     prod;

  always_comb begin
    red_w    = (GRAY_SUM_W'(red) << 1) + GRAY_SUM_W'(red);
    green_w  = (GRAY_SUM_W'(green) << 2) + (GRAY_SUM_W'(green) << 1);
    weighted = red_w + green_w + GRAY_SUM_W'(blue);
    prod     = PROD_W'(weighted) * PROD_W'(RECIP_10);
  end

  always_comb begin
    col_cur = row_start ? '0 : col_cnt;
    in_line = col_cur < COL_W'(IMAGE_WIDTH);
    // saturate past the line store
    col_cnt_next = in_line ? col_cur + COL_W'(1) : col_cur;
  end

  always_comb begin
    item.gray      = prod[RECIP_SHIFT +: PIX_W];
    item.col       = col_cur;
    item.in_line   = in_line;
    item.first_row = frame_first_row;
    item.row_start = row_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
    end else if (take) begin
      col_cnt <= col_cnt_next;
    end
  end

endmodule

### rtl/rgi_queue.sv
module rgi_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  rgi_pkg::item_t       push_item,
  input  logic                 pop,
  output rgi_pkg::item_t       head,
  output rgi_pkg::queue_stat_t stat
);
  import rgi_pkg::*;

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_comb begin
    head       = entries[rd_ptr];
    stat.full  = count == QCNT_W'(QUEUE_DEPTH);
    stat.empty = count == '0;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

### rtl/rgi_back.sv
module rgi_back (
  input  logic                       clk,
  input  logic                       rst,
  input  rgi_pkg::item_t             head,
  input  logic                       head_valid,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rgi_pkg::AREA_W-1:0] area_sum,
  output logic [rgi_pkg::PIX_W-1:0]  gray_value
);
  import rgi_pkg::*;

  logic [AREA_W-1:0] line_mem [IMAGE_WIDTH];

  logic [ROW_W-1:0]  row_sum;
  logic [ROW_W-1:0]  row_sum_next;
  logic              s1_valid;
  item_t             s1_item;
  logic [ROW_W-1:0]  s1_row;
  logic [AREA_W-1:0] mem_rd;
  logic              byp_hit;
  logic [AREA_W-1:0] byp_val;
  logic [AREA_W-1:0] above;
  logic [AREA_W-1:0] s1_area;
  logic              out_free;
  logic              s1_go;
  logic              hit_next;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [AREA_W-1:0] out_area;
  logic [PIX_W-1:0]  out_gray;

  always_comb begin
    out_free = !out_valid || out_ready;
    s1_go    = s1_valid && out_free;
    pop      = head_valid && (!s1_valid || s1_go);

    rd_addr = head.col[ADDR_W-1:0];
    wr_addr = s1_item.col[ADDR_W-1:0];

    row_sum_next = (head.row_start ? '0 : row_sum) + ROW_W'(head.gray);

    // value above: zero in the first row and past the line store
    if (s1_item.first_row || !s1_item.in_line) begin
      above = '0;
    end else if (byp_hit) begin
      above = byp_val;
    end else begin
      above = mem_rd;
    end
    s1_area = AREA_W'(s1_row) + above;

    // the item leaving s1 writes on the same edge the new one reads
    hit_next = s1_go && s1_item.in_line && (s1_item.col == head.col);

    area_sum   = out_area;
    gray_value = out_gray;
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_item.in_line) begin
      line_mem[wr_addr] <= s1_area;
    end
    if (pop && head.in_line) begin
      mem_rd <= line_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_item <= head;
      s1_row  <= row_sum_next;
      byp_hit <= hit_next;
      byp_val <= s1_area;
    end
    if (s1_go) begin
      out_area <= s1_area;
      out_gray <= s1_item.gray;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum   <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        row_sum  <= row_sum_next;
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/rgb_gray_integral_image.sv
// RGB to gray integral image (summed-area table).
// Input stream s_axis: one RGB pixel per request in raster order. tdata holds
// red, green, blue; tuser flags column zero of a row and the first row of a
// frame. Output stream m_axis: one request per pixel with the integral value
// (gray sum of the rectangle up to the pixel, mod 2^24) and its gray level
// (3R + 6G + B) / 10, truncated.
// Throughput: one pixel per cycle while m_axis_tready stays high; the line
// store (one read and one write per cycle) sets that figure.
// Path: an accepted pixel goes through the queue, s1 and the output register.
// Stall: results collect in the output register, one working stage and a
// four-entry queue; s_axis_tready drops only when that queue is full, so up
// to six pixels are absorbed while the receiver stalls.
// Reset clears the row sum, column counter, queue and all valid flags. The
// line store is not cleared: a frame's first row never reads it; each later
// row must read only columns written by the row before; the block does not
// enforce it. Rows past the line store keep summing, taking zero from above.
module rgb_gray_integral_image (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red, green, blue
  input  logic [1:0]  s_axis_tuser,  // row_start, frame_first_row
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // area_sum, gray_value
);
  import rgi_pkg::*;

  logic              take;
  logic              pop;
  item_t             front_item;
  item_t             head;
  queue_stat_t       qstat;
  logic [AREA_W-1:0] area_sum;
  logic [PIX_W-1:0]  gray_value;

  assign take          = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !qstat.full;
  assign m_axis_tdata  = {gray_value, area_sum};

  rgi_front u_front (
    .clk             (clk),
    .rst             (rst),
    .red             (s_axis_tdata[7:0]),
    .green           (s_axis_tdata[15:8]),
    .blue            (s_axis_tdata[23:16]),
    .row_start       (s_axis_tuser[0]),
    .frame_first_row (s_axis_tuser[1]),
    .take            (take),
    .item            (front_item)
  );

  rgi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_item (front_item),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  rgi_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!qstat.empty),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .area_sum   (area_sum),
    .gray_value (gray_value)
  );

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    take |-> !qstat.full)
    else $error("queue pushed while full");

  a_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (qstat.empty && !take) |=> !pop)
    else $error("pop on empty queue after idle cycle");
`endif

endmodule

### tb/gray_area_checker.sv
module gray_area_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red, green, blue
  input  logic [1:0]  s_axis_tuser,   // row_start, frame_first_row
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // area_sum, gray_value
  output int          mismatch_count,
  output int          awaited_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import rgi_pkg::*;

  localparam int ROW_START_BIT = 0;
  localparam int FIRST_ROW_BIT = 1;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic [PIX_W-1:0]  gray;
  } area_px_t;

  area_px_t          awaited_sums[$];
  logic [ROW_W-1:0]  row_sum;
  logic [COL_W-1:0]  col;
  logic [AREA_W-1:0] line_sums[IMAGE_WIDTH];
  int                fail_tally = 0;

  function automatic logic [PIX_W-1:0] gray_level(input logic [23:0] rgb);
    int weighted;
    weighted = 3 * rgb[7:0] + 6 * rgb[15:8] + rgb[23:16];
    return PIX_W'(weighted / 10);
  endfunction

  task automatic predict_area(input logic [23:0] rgb, input logic [1:0] flags);
    logic [PIX_W-1:0]  gray;
    logic [AREA_W-1:0] above;
    area_px_t          px;
    if (flags[ROW_START_BIT]) begin
      row_sum = '0;
      col = '0;
    end
    gray = gray_level(rgb);
    row_sum = row_sum + ROW_W'(gray);
    // past the line store, or in the first row, nothing comes from above
    above = '0;
    if (col < IMAGE_WIDTH && !flags[FIRST_ROW_BIT]) begin
      above = line_sums[col];
    end
    px.area = AREA_W'(row_sum) + above;
    px.gray = gray;
    if (col < IMAGE_WIDTH) begin
      line_sums[col] = px.area;
      col = col + 1'b1;
    end
    awaited_sums.push_back(px);
  endtask

  always @(posedge clk) begin
    area_px_t px;
    if (rst) begin
      row_sum = '0;
      col = '0;
      awaited_sums.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_area(s_axis_tdata, s_axis_tuser);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_sums.size() == 0) begin
          $display("%0t: result with none expected: area_sum %0d gray_value %0d",
                   $time, m_axis_tdata[23:0], m_axis_tdata[31:24]);
          fail_tally++;
        end else begin
          px = awaited_sums.pop_front();
          if (m_axis_tdata[23:0] !== px.area) begin
            $display("%0t: area_sum expected %0d actual %0d",
                     $time, px.area, m_axis_tdata[23:0]);
            fail_tally++;
          end
          if (m_axis_tdata[31:24] !== px.gray) begin
            $display("%0t: gray_value expected %0d actual %0d",
                     $time, px.gray, m_axis_tdata[31:24]);
            fail_tally++;
          end
        end
      end
    end
    mismatch_count <= fail_tally;
    awaited_count <= awaited_sums.size();
  end

endmodule

### tb/rgb_gray_integral_image_test.sv
module rgb_gray_integral_image_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rgi_pkg::*;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [31:0] m_axis_tdata;
  int          mismatch_count;
  int          awaited_count;

  int burst_left = 0;
  int next_col = 0;
  int written_cols = 0;
  int items_sent = 0;

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_tick = 0;

  rgb_gray_integral_image u_dut (.*);
  gray_area_checker u_check (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver: phases of open flow, coin flips, sparse accepts and a fixed cadence
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(5, 80);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default:   m_axis_tready <= (rx_tick % 4 != 0);
    endcase
  end

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic row_start, input logic first_row);
    int col;
    col = row_start ? 0 : next_col;
    // never read a line-store column that no earlier row has filled
    if (col < IMAGE_WIDTH && col >= written_cols) begin
      first_row = 1'b1;
    end
    if (col < IMAGE_WIDTH) begin
      if (col + 1 > written_cols) begin
        written_cols = col + 1;
      end
      next_col = col + 1;
    end else begin
      next_col = IMAGE_WIDTH;
    end
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b, g, r};
    s_axis_tuser <= {first_row, row_start};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_row(input int len, input logic first_row);
    for (int i = 0; i < len; i++) begin
      send_pixel(pick_level(), pick_level(), pick_level(), i == 0, first_row);
    end
  endtask

  // hold off until every request sent so far has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (awaited_count != 0);
  endtask

  initial begin
    int len;
    bit paused_mid;
    paused_mid = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // first frame row, entered straight after reset without a row start
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b0, 1'b1);
    send_pixel(8'd3, 8'd1, 8'd1, 1'b0, 1'b1);
    send_pixel(8'd0, 8'd1, 8'd3, 1'b0, 1'b1);
    send_pixel(8'd1, 8'd1, 8'd1, 1'b0, 1'b1);
    // second row adds the sums above; one pixel mid-row claims first row
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
    send_pixel(8'd128, 8'd64, 8'd32, 1'b0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    send_pixel(8'd17, 8'd200, 8'd99, 1'b0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
    send_pixel(8'd10, 8'd20, 8'd30, 1'b0, 1'b1);
    send_pixel(8'd200, 8'd100, 8'd50, 1'b0, 1'b0);
    // one-pixel frame, then a short row under it
    send_pixel(8'd9, 8'd9, 8'd9, 1'b1, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
    send_pixel(8'd1, 8'd2, 8'd3, 1'b0, 1'b0);
    send_pixel(8'd254, 8'd254, 8'd254, 1'b0, 1'b0);
    drain();

    while (items_sent < 120) begin
      len = ($urandom_range(0, 4) == 0) ? IMAGE_WIDTH : $urandom_range(1, 40);
      case ($urandom_range(0, 9))
        0, 1: send_row(len, 1'b1);
        7: send_row(($urandom_range(0, 1) == 1) ? IMAGE_WIDTH
                                                : IMAGE_WIDTH + $urandom_range(1, 30),
                    1'($urandom_range(0, 1)));
        8: begin
          for (int i = 0; i < 20; i++) begin
            send_pixel(pick_level(), pick_level(), pick_level(),
                       $urandom_range(0, 5) == 0, 1'($urandom_range(0, 1)));
          end
        end
        9: send_row($urandom_range(1, 3), 1'b0);
        default: send_row(len, 1'b0);
      endcase
      if (!paused_mid && items_sent >= 60) begin
        paused_mid = 1'b1;
        drain();
      end
    end

    // overlong white row: the row sum wraps past its width
    for (int i = 0; i < 1030; i++) begin
      send_pixel(8'd255, 8'd255, 8'd255, i == 0, 1'b0);
    end
    send_row(16, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
